FILE: design/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int COORD_BITS    = 12;
    // A radius never exceeds half the coordinate range, so it fits COORD_BITS bits.
    localparam int RAD_W         = COORD_BITS;
    localparam int SQ_W          = 2 * RAD_W - 1;
    localparam int MUL_W         = 2 * SQ_W;
    localparam int OFS_W         = COORD_BITS + 2;
    localparam int DEC_W         = 4 * COORD_BITS + 8;
    localparam int PTS_PER_STEP  = 4;
    localparam int PT_W          = $clog2(PTS_PER_STEP);
    localparam logic [PT_W-1:0] PT_LAST = PT_W'(PTS_PER_STEP - 1);
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = Q_PTR_W + 1;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        RGN_ONE  = 2'd0,
        RGN_TWO  = 2'd1,
        RGN_DONE = 2'd2
    } t_region;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_RX,
        BK_MUL_RY,
        BK_MUL_Q,
        BK_MUL_R,
        BK_INIT,
        BK_CHECK,
        BK_R2INIT,
        BK_UPDATE,
        BK_EMIT,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] corner_a_x;
        logic [COORD_BITS-1:0] corner_a_y;
        logic [COORD_BITS-1:0] corner_b_x;
        logic [COORD_BITS-1:0] corner_b_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  point_valid;
        logic                  last_of_step;
        logic                  finished;
    } t_out_item;

    typedef struct packed {
        logic                  is_step;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RAD_W-1:0]      rad_x;
        logic [RAD_W-1:0]      rad_y;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic not_empty;
        t_cmd cmd;
    } t_q_rd;

endpackage

FILE: design/mer_front.sv
// Front end: takes input items, classifies them and derives center and radii.
module mer_front
    import mer_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output t_q_wr    o_q_wr
);

    logic [COORD_BITS:0]   sum_x;
    logic [COORD_BITS:0]   sum_y;
    logic [COORD_BITS-1:0] cen_x;
    logic [COORD_BITS-1:0] cen_y;

    // Center is the halved corner sum, rounded down.
    assign sum_x = {1'b0, i_in_item.corner_a_x} + {1'b0, i_in_item.corner_b_x};
    assign sum_y = {1'b0, i_in_item.corner_a_y} + {1'b0, i_in_item.corner_b_y};
    assign cen_x = sum_x[COORD_BITS:1];
    assign cen_y = sum_y[COORD_BITS:1];

    assign o_in_stall = i_q_full;

    always_comb begin
        o_q_wr.valid        = i_in_valid && !i_q_full;
        o_q_wr.cmd.is_step  = (i_in_item.req_type == REQ_STEP);
        o_q_wr.cmd.center_x = cen_x;
        o_q_wr.cmd.center_y = cen_y;
        if (i_in_item.corner_a_x >= cen_x) begin
            o_q_wr.cmd.rad_x = i_in_item.corner_a_x - cen_x;
        end else begin
            o_q_wr.cmd.rad_x = cen_x - i_in_item.corner_a_x;
        end
        if (i_in_item.corner_a_y >= cen_y) begin
            o_q_wr.cmd.rad_y = i_in_item.corner_a_y - cen_y;
        end else begin
            o_q_wr.cmd.rad_y = cen_y - i_in_item.corner_a_y;
        end
    end

endmodule

FILE: design/mer_queue.sv
// Short command queue between the front end and the back end.
module mer_queue
    import mer_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    input  logic  i_pop,
    output logic  o_full,
    output t_q_rd o_rd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full         = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_rd.not_empty = (r_count != '0);
    assign o_rd.cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_wr.valid && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_wr.valid && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

endmodule

FILE: design/mer_back.sv
// Back end: sequencer with shared multiplier, incremental decision update and output register.
module mer_back
    import mer_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_rd     i_rd,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    t_back_state r_state, n_state;
    t_region     r_region, n_region;
    logic [PT_W-1:0] r_pt, n_pt;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic [COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [RAD_W-1:0]      r_rx, n_rx, r_ry, n_ry;
    logic [SQ_W-1:0]       r_rx2, n_rx2, r_ry2, n_ry2;
    logic [OFS_W-1:0]      r_x, n_x, r_y, n_y;
    // P = ry2*x, Q = rx2*y, S = ry2*x*x, T = rx2*y*y, RR = rx2*ry2.
    logic signed [DEC_W-1:0] r_p, n_p, r_q, n_q, r_s, n_s, r_t, n_t;
    logic signed [DEC_W-1:0] r_rr, n_rr, r_d, n_d, r_tmp, n_tmp;

    logic [SQ_W-1:0]  mul_a, mul_b;
    logic [MUL_W-1:0] mul_p;

    logic signed [DEC_W-1:0] rx2_e, ry2_e, rx2_12, ry2_12, gain;
    logic                    r1_goes_on, d_neg, out_free;
    logic [COORD_BITS-1:0]   x_c, y_c;

    assign mul_p  = mul_a * mul_b;
    assign rx2_e  = DEC_W'(r_rx2);
    assign ry2_e  = DEC_W'(r_ry2);
    assign rx2_12 = (rx2_e <<< 3) + (rx2_e <<< 2);
    assign ry2_12 = (ry2_e <<< 3) + (ry2_e <<< 2);
    assign gain   = (r_p <<< 3) + ry2_12;
    assign d_neg  = r_d[DEC_W-1];
    // Region one continues while 2*ry2*(x+1) < rx2*(2y-1).
    assign r1_goes_on = (r_y != '0) && (((r_p <<< 1) + (ry2_e <<< 1)) < ((r_q <<< 1) - rx2_e));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign x_c = r_x[COORD_BITS-1:0];
    assign y_c = r_y[COORD_BITS-1:0];

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state     = r_state;
        n_region    = r_region;
        n_pt        = r_pt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_rx  = r_rx;
        n_ry  = r_ry;
        n_rx2 = r_rx2;
        n_ry2 = r_ry2;
        n_x   = r_x;
        n_y   = r_y;
        n_p   = r_p;
        n_q   = r_q;
        n_s   = r_s;
        n_t   = r_t;
        n_rr  = r_rr;
        n_d   = r_d;
        n_tmp = r_tmp;
        mul_a = '0;
        mul_b = '0;
        o_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_rd.not_empty) begin
                    o_pop = 1'b1;
                    if (i_rd.cmd.is_step) begin
                        n_state = BK_CHECK;
                    end else begin
                        n_cx    = i_rd.cmd.center_x;
                        n_cy    = i_rd.cmd.center_y;
                        n_rx    = i_rd.cmd.rad_x;
                        n_ry    = i_rd.cmd.rad_y;
                        n_state = BK_MUL_RX;
                    end
                end
            end
            BK_MUL_RX: begin
                mul_a   = SQ_W'(r_rx);
                mul_b   = SQ_W'(r_rx);
                n_rx2   = mul_p[SQ_W-1:0];
                n_state = BK_MUL_RY;
            end
            BK_MUL_RY: begin
                mul_a   = SQ_W'(r_ry);
                mul_b   = SQ_W'(r_ry);
                n_ry2   = mul_p[SQ_W-1:0];
                n_state = BK_MUL_Q;
            end
            BK_MUL_Q: begin
                mul_a   = r_rx2;
                mul_b   = SQ_W'(r_ry);
                n_q     = DEC_W'(mul_p);
                n_state = BK_MUL_R;
            end
            BK_MUL_R: begin
                mul_a   = r_rx2;
                mul_b   = r_ry2;
                n_rr    = DEC_W'(mul_p);
                n_t     = DEC_W'(mul_p);
                n_state = BK_INIT;
            end
            BK_INIT: begin
                n_d      = (ry2_e <<< 2) - (r_q <<< 2) + rx2_e;
                n_region = RGN_ONE;
                n_x      = '0;
                n_y      = OFS_W'(r_ry);
                n_p      = '0;
                n_s      = '0;
                n_state  = BK_IDLE;
            end
            BK_CHECK: begin
                if (r_region == RGN_ONE && !r1_goes_on) begin
                    // Enter region two: first half of the squared start form.
                    n_region = RGN_TWO;
                    n_tmp    = (r_s <<< 2) + (r_p <<< 2) + (r_t <<< 2) - (r_rr <<< 2);
                    n_state  = BK_R2INIT;
                end else begin
                    n_state  = BK_UPDATE;
                end
            end
            BK_R2INIT: begin
                n_d     = r_tmp + ry2_e - (r_q <<< 3) + (rx2_e <<< 2);
                n_state = BK_UPDATE;
            end
            BK_UPDATE: begin
                case (r_region)
                    RGN_ONE: begin
                        n_x = r_x + OFS_W'(1);
                        n_p = r_p + ry2_e;
                        n_s = r_s + (r_p <<< 1) + ry2_e;
                        if (d_neg) begin
                            n_d = r_d + gain;
                        end else begin
                            n_d = r_d + gain + (rx2_e <<< 3) - (r_q <<< 3);
                            n_y = r_y - OFS_W'(1);
                            n_q = r_q - rx2_e;
                            n_t = r_t - (r_q <<< 1) + rx2_e;
                        end
                        n_pt    = '0;
                        n_state = BK_EMIT;
                    end
                    RGN_TWO: begin
                        if (r_y == '0) begin
                            n_region = RGN_DONE;
                            n_state  = BK_DONE;
                        end else begin
                            n_y = r_y - OFS_W'(1);
                            n_q = r_q - rx2_e;
                            n_t = r_t - (r_q <<< 1) + rx2_e;
                            if (d_neg) begin
                                n_x = r_x + OFS_W'(1);
                                n_p = r_p + ry2_e;
                                n_s = r_s + (r_p <<< 1) + ry2_e;
                                n_d = r_d + (r_p <<< 3) - (r_q <<< 3) + (ry2_e <<< 3)
                                    + rx2_12;
                            end else begin
                                n_d = r_d + rx2_12 - (r_q <<< 3);
                            end
                            n_pt    = '0;
                            n_state = BK_EMIT;
                        end
                    end
                    default: begin
                        n_state = BK_DONE;
                    end
                endcase
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.point_x      = r_pt[1] ? (r_cx - x_c) : (r_cx + x_c);
                    n_out_item.point_y      = r_pt[0] ? (r_cy - y_c) : (r_cy + y_c);
                    n_out_item.point_valid  = 1'b1;
                    n_out_item.last_of_step = (r_pt == PT_LAST);
                    n_out_item.finished     = 1'b0;
                    if (r_pt == PT_LAST) begin
                        n_pt    = '0;
                        n_state = BK_IDLE;
                    end else begin
                        n_pt = r_pt + PT_W'(1);
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.point_x      = '0;
                    n_out_item.point_y      = '0;
                    n_out_item.point_valid  = 1'b0;
                    n_out_item.last_of_step = 1'b1;
                    n_out_item.finished     = 1'b1;
                    n_state                 = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_region    <= RGN_DONE;
            r_pt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_region    <= n_region;
            r_pt        <= n_pt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_rx  <= n_rx;
        r_ry  <= n_ry;
        r_rx2 <= n_rx2;
        r_ry2 <= n_ry2;
        r_x   <= n_x;
        r_y   <= n_y;
        r_p   <= n_p;
        r_q   <= n_q;
        r_s   <= n_s;
        r_t   <= n_t;
        r_rr  <= n_rr;
        r_d   <= n_d;
        r_tmp <= n_tmp;
    end

endmodule

FILE: design/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
// A start item (req_type 0) takes two bounding-box corners: the center is their
// halved sum per axis, rounded down, and the radii are the distances of corner A
// from it; a start item returns nothing. Each step item (req_type 1) advances the
// two-region midpoint walk by one pixel step and returns four mirrored points in
// the order (cx+x,cy+y), (cx+x,cy-y), (cx-x,cy+y), (cx-x,cy-y), the last one
// flagged last_of_step; coordinates wrap to 12 bits. A step on a finished outline,
// after reset, or for a zero y radius returns one item with point_valid 0,
// last_of_step 1 and finished 1. Items pass a two-entry queue from the front end
// to a back-end sequencer, so up to two items are still taken while the back end
// works or the output is stalled. The back end keeps the decision value scaled by
// four and tracks ry^2*x, rx^2*y and their squared forms incrementally, so a step
// needs only adds: a pixel step runs the check, the region-two setup on the step
// that enters region two and the update, then emits its four points one at a
// time through the single-point output register, waiting while it is stalled; a
// start runs the one shared multiplier that forms rx^2, ry^2, rx^2*ry and
// rx^2*ry^2, then sets up the walk; a finished step ends in its finished item.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    // Classify the item and derive center and radii.
    mer_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_q_wr     (q_wr)
    );

    // Decouple intake from execution.
    mer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_rd    (q_rd)
    );

    // Run the walk and drive the output register.
    mer_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .i_out_stall (i_out_stall),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/mer_checker.sv
// Port-level checks of the midpoint ellipse rasterizer, bound to its top level.
module mer_checker
    import mer_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Drop any pending result on reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_finished_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |->
            !o_out_item.point_valid && o_out_item.last_of_step)
        else $error("finished item carries a pixel or is not last");

    a_pixel_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.point_valid |-> !o_out_item.finished)
        else $error("pixel item flagged finished");

    // The queue only fills up after taking an item.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted item");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
